// ----- rtl/ffra_pkg.sv -----
package ffra_pkg;

    // Field widths
    localparam int POS_W   = 17;
    localparam int LEN_W   = 17;
    localparam int OWNER_W = 7;

    // Operation codes
    localparam logic OP_CLAIM   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Reset value of the size register
    localparam logic [POS_W-1:0] TOTAL_SIZE_RST = 17'h10000;

    // One run table entry, inclusive bounds
    typedef struct packed {
        logic [POS_W-1:0]   run_start;
        logic [POS_W-1:0]   run_end;
        logic [OWNER_W-1:0] run_owner;
    } t_run;

endpackage

// ----- rtl/first_fit_range_allocator.sv -----
// First-fit allocator of contiguous position runs 1..total_size, one run per owner.
// Input channel (i_in_valid / o_in_stall) carries i_op, i_owner_id, i_request_length;
// a claim takes the lowest gap that fits, a release removes the owner's run.
// Output channel (o_out_valid / i_out_stall) returns one o_granted per transaction.
// Config channel (i_cfg_valid / o_cfg_ready) writes total_size; ready is always high,
// and a write is expected only while no transaction is in flight.
// The run table sits in one memory (one write, one registered read port), sorted
// by start. Each transaction walks the table once through the read port, then shifts
// entries one per cycle to insert or close up. Requests refused on sight (bad owner,
// zero length, full table) skip the walk and go straight to the result.
// One transaction is handled at a time; the input stalls until it finishes.
// A finished result waits in the output register while the next transaction is
// taken; if the receiver still stalls when that one finishes, the block holds.
// Synchronous reset empties the table (run count to zero, no clearing pass),
// drops any pending result and sets total_size to 65536.
module first_fit_range_allocator
    import ffra_pkg::*;
#(
    parameter int MAX_RUNS   = 64,
    parameter int NUM_OWNERS = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [POS_W-1:0]   i_cfg_total_size,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_op,
    input  logic [OWNER_W-1:0] i_owner_id,
    input  logic [LEN_W-1:0]   i_request_length,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_granted
);

    localparam int IW = $clog2(MAX_RUNS);
    localparam int CW = $clog2(MAX_RUNS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_INS,
        S_DEL,
        S_DONE
    } t_state;

    t_state r_state, n_state;

    // Control registers
    logic [CW-1:0]    r_count, n_count;
    logic [POS_W-1:0] r_total, n_total;
    logic             r_out_valid, n_out_valid;
    logic             r_rvalid, n_rvalid;

    // Per-transaction working registers
    logic               r_op, n_op;
    logic [OWNER_W-1:0] r_owner, n_owner;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [CW-1:0]      r_idx, n_idx;
    logic [CW-1:0]      r_ridx, n_ridx;
    logic [CW-1:0]      r_slot, n_slot;
    logic [CW-1:0]      r_hit, n_hit;
    logic               r_found, n_found;
    logic               r_present, n_present;
    logic [POS_W-1:0]   r_prev_end, n_prev_end;
    logic               r_res, n_res;
    logic               r_granted, n_granted;

    // Run table memory
    t_run             r_run_mem [MAX_RUNS];
    t_run             r_rd_data;
    logic             mem_we;
    logic [IW-1:0]    mem_waddr;
    logic [IW-1:0]    mem_raddr;
    t_run             mem_wdata;

    // Helpers
    logic [POS_W:0]   sum_len;
    logic [CW-1:0]    idx_dec;
    logic [CW-1:0]    ridx_inc;
    logic [CW-1:0]    ridx_dec;
    logic             owner_oob;

    assign sum_len   = {1'b0, r_prev_end} + {1'b0, r_len};
    assign idx_dec   = r_idx - CW'(1);
    assign ridx_inc  = r_ridx + CW'(1);
    assign ridx_dec  = r_ridx - CW'(1);
    assign owner_oob = !(32'(i_owner_id) < 32'(NUM_OWNERS));

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_granted   = r_granted;

    // Memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_run_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_run_mem[mem_raddr];
    end

    // Sequencer next-state logic
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_total     = r_total;
        n_out_valid = r_out_valid;
        n_rvalid    = 1'b0;
        n_op        = r_op;
        n_owner     = r_owner;
        n_len       = r_len;
        n_idx       = r_idx;
        n_ridx      = r_ridx;
        n_slot      = r_slot;
        n_hit       = r_hit;
        n_found     = r_found;
        n_present   = r_present;
        n_prev_end  = r_prev_end;
        n_res       = r_res;
        n_granted   = r_granted;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_raddr   = '0;
        mem_wdata   = r_rd_data;

        // Take config writes
        if (i_cfg_valid) begin
            n_total = i_cfg_total_size;
        end

        // Drop a delivered result
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op       = i_op;
                    n_owner    = i_owner_id;
                    n_len      = i_request_length;
                    n_idx      = '0;
                    n_slot     = r_count;
                    n_hit      = '0;
                    n_found    = 1'b0;
                    n_present  = 1'b0;
                    n_prev_end = '0;
                    n_res      = 1'b0;
                    if (owner_oob || (i_op == OP_CLAIM && (i_request_length == '0
                            || r_count == CW'(MAX_RUNS)))) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                // Issue the next table read
                if (r_idx < r_count) begin
                    mem_raddr = r_idx[IW-1:0];
                    n_ridx    = r_idx;
                    n_idx     = r_idx + CW'(1);
                    n_rvalid  = 1'b1;
                end
                // Check the entry that came back: first gap, owner match
                if (r_rvalid) begin
                    if (!r_found) begin
                        if ({1'b0, r_rd_data.run_start} > sum_len) begin
                            n_found = 1'b1;
                            n_slot  = r_ridx;
                        end else begin
                            n_prev_end = r_rd_data.run_end;
                        end
                    end
                    if (!r_present && r_rd_data.run_owner == r_owner) begin
                        n_present = 1'b1;
                        n_hit     = r_ridx;
                    end
                end
                if (r_idx == r_count && !r_rvalid) begin
                    n_state = S_DECIDE;
                end
            end

            S_DECIDE: begin
                if (r_op == OP_RELEASE) begin
                    if (!r_present) begin
                        n_res   = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        n_idx   = r_hit + CW'(1);
                        n_state = S_DEL;
                    end
                end else begin
                    if (r_present || (!r_found && sum_len > {1'b0, r_total})) begin
                        n_res   = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        n_idx   = r_count;
                        n_state = S_INS;
                    end
                end
            end

            S_INS: begin
                // Walk down from the top, moving each entry up by one
                if (r_idx > r_slot) begin
                    mem_raddr = idx_dec[IW-1:0];
                    n_ridx    = idx_dec;
                    n_idx     = idx_dec;
                    n_rvalid  = 1'b1;
                end
                if (r_rvalid) begin
                    mem_we    = 1'b1;
                    mem_waddr = ridx_inc[IW-1:0];
                    mem_wdata = r_rd_data;
                end
                // Write the new run into the opened slot
                if (r_idx == r_slot && !r_rvalid) begin
                    mem_we              = 1'b1;
                    mem_waddr           = r_slot[IW-1:0];
                    mem_wdata.run_start = r_prev_end + POS_W'(1);
                    mem_wdata.run_end   = sum_len[POS_W-1:0];
                    mem_wdata.run_owner = r_owner;
                    n_count             = r_count + CW'(1);
                    n_res               = 1'b1;
                    n_state             = S_DONE;
                end
            end

            S_DEL: begin
                // Walk up past the removed run, moving each entry down by one
                if (r_idx < r_count) begin
                    mem_raddr = r_idx[IW-1:0];
                    n_ridx    = r_idx;
                    n_idx     = r_idx + CW'(1);
                    n_rvalid  = 1'b1;
                end
                if (r_rvalid) begin
                    mem_we    = 1'b1;
                    mem_waddr = ridx_dec[IW-1:0];
                    mem_wdata = r_rd_data;
                end
                if (r_idx >= r_count && !r_rvalid) begin
                    n_count = r_count - CW'(1);
                    n_res   = 1'b1;
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                // Hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_granted   = r_res;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, control and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_total     <= TOTAL_SIZE_RST;
            r_out_valid <= 1'b0;
            r_rvalid    <= 1'b0;
            r_granted   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
            r_rvalid    <= n_rvalid;
            r_granted   <= n_granted;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_owner    <= n_owner;
        r_len      <= n_len;
        r_idx      <= n_idx;
        r_ridx     <= n_ridx;
        r_slot     <= n_slot;
        r_hit      <= n_hit;
        r_found    <= n_found;
        r_present  <= n_present;
        r_prev_end <= n_prev_end;
        r_res      <= n_res;
    end

endmodule
